FILE: sv/assert_macros.svh
// Assertion macros for the RTL modules of the escape-time pixel block.
// Depends on nothing; each user module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/mandel_pkg.sv
// Package for the escape-time pixel block: widths, register codes and
// the request/response types of the color divider. Depends on nothing.
package mandel_pkg;

    // Payload widths.
    localparam int COL_W  = 10;
    localparam int ROW_W  = 9;
    localparam int ITER_W = 16;
    localparam int Z_W    = 32;
    localparam int PROD_W = 64;

    // Divider widths: escape step times 255 over max_iter.
    localparam int DVD_W = 24;
    localparam int DVS_W = 16;
    localparam int QUO_W = 8;

    // Configuration register indexes.
    localparam logic [2:0] CFG_X_START  = 3'd0;
    localparam logic [2:0] CFG_Y_START  = 3'd1;
    localparam logic [2:0] CFG_X_STEP   = 3'd2;
    localparam logic [2:0] CFG_Y_STEP   = 3'd3;
    localparam logic [2:0] CFG_MAX_ITER = 3'd4;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quotient;
    } t_div_rsp;

endpackage

FILE: sv/mandel_pix_if.sv
// Pixel coordinate channel: valid/ready handshake with column and row.
// Depends on mandel_pkg for the field widths.
interface mandel_pix_if;
    logic                           valid;
    logic                           ready;
    logic [mandel_pkg::COL_W-1:0]   col;
    logic [mandel_pkg::ROW_W-1:0]   row;

    modport source (output valid, output col, output row, input ready);
    modport sink   (input valid, input col, input row, output ready);
endinterface

FILE: sv/mandel_rgb_if.sv
// Pixel color channel: valid/ready handshake with color bytes and escape data.
// Depends on mandel_pkg for the field widths.
interface mandel_rgb_if;
    logic                           valid;
    logic                           ready;
    logic [7:0]                     red;
    logic [6:0]                     green;
    logic [6:0]                     blue;
    logic                           in_set;
    logic [mandel_pkg::ITER_W-1:0]  escape_step;

    modport source (output valid, output red, output green, output blue,
                    output in_set, output escape_step, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input in_set, input escape_step, output ready);
endinterface

FILE: sv/mandelbrot_escape_time_pixel.sv
// Escape-time pixel: one transaction in, one color transaction out.
// Sequence: form c, then orbit passes (products, then update and test), at most
// max_iter + 1 passes, then a color divide on escape before the output register.
// Ready only when idle: a new pixel is taken once the last has reached the output register.
// Reset (synchronous, active low) restores the register defaults and idles.
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    mandel_pix_if.sink          i_pix,
    mandel_rgb_if.source        o_rgb
);

    localparam int C_W = 43;
    localparam int N_W = 45;
    localparam logic signed [N_W-1:0] COMP_LIMIT = N_W'(64'sd1073741824);
    localparam logic [mandel_pkg::PROD_W:0] ESC_BOUND = (mandel_pkg::PROD_W+1)'(1) << 58;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_INIT   = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_UPD    = 7'b0001000,
        ST_DSTART = 7'b0010000,
        ST_DWAIT  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic signed [31:0]                 r_x_start, r_y_start, r_x_step, r_y_step;
    logic [mandel_pkg::ITER_W-1:0]      r_max_iter;

    // Per-pixel working state.
    logic [mandel_pkg::COL_W-1:0]       r_col;
    logic [mandel_pkg::ROW_W-1:0]       r_row;
    logic signed [C_W-1:0]              r_cr, r_ci;
    logic signed [mandel_pkg::Z_W-1:0]  r_zr, r_zi;
    logic [mandel_pkg::ITER_W-1:0]      r_k;
    logic [mandel_pkg::ITER_W-1:0]      r_esc;
    logic                               r_set;

    // Output register.
    logic                               r_out_valid;
    logic [7:0]                         r_out_red;
    logic [6:0]                         r_out_green;
    logic [6:0]                         r_out_blue;
    logic                               r_out_in_set;
    logic [mandel_pkg::ITER_W-1:0]      r_out_esc;

    logic signed [mandel_pkg::PROD_W-1:0] w_sq_r, w_sq_i, w_cross;
    logic signed [C_W-1:0]              w_cr_prod, w_ci_prod;
    logic signed [mandel_pkg::PROD_W:0] w_re_full;
    logic signed [N_W-1:0]              w_nzr, w_nzi;
    logic [mandel_pkg::PROD_W:0]        w_mag;
    logic                               w_mag_esc, w_oob, w_at_max, w_out_free;
    mandel_pkg::t_div_req               w_div_req;
    mandel_pkg::t_div_rsp               w_div_rsp;

    // Squaring unit, fed from the orbit registers.
    mandel_sq_unit u_sq (
        .i_clk   (i_clk),
        .i_en    (r_state == ST_MUL),
        .i_zr    (r_zr),
        .i_zi    (r_zi),
        .o_sq_r  (w_sq_r),
        .o_sq_i  (w_sq_i),
        .o_cross (w_cross)
    );

    // Color divider.
    assign w_div_req.start    = (r_state == ST_DSTART);
    assign w_div_req.dividend = ({r_esc, 8'd0} - {8'd0, r_esc});
    assign w_div_req.divisor  = r_max_iter;

    mandel_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Point c from the pixel index.
    assign w_cr_prod = C_W'(r_x_step) * C_W'($signed({1'b0, r_col}));
    assign w_ci_prod = C_W'(r_y_step) * C_W'($signed({1'b0, r_row}));

    // Orbit update with floor shifts, and the escape tests.
    assign w_re_full = $signed({w_sq_r[mandel_pkg::PROD_W-1], w_sq_r})
                     - $signed({w_sq_i[mandel_pkg::PROD_W-1], w_sq_i});
    assign w_nzr = $signed({{8{w_re_full[64]}}, w_re_full[64:28]})
                 + $signed({{2{r_cr[C_W-1]}}, r_cr});
    assign w_nzi = $signed({{8{w_cross[63]}}, w_cross[63:27]})
                 + $signed({{2{r_ci[C_W-1]}}, r_ci});
    assign w_oob = (w_nzr > COMP_LIMIT) || (w_nzr < -COMP_LIMIT)
                || (w_nzi > COMP_LIMIT) || (w_nzi < -COMP_LIMIT);
    // Both squares are non-negative, so the sum is taken unsigned.
    assign w_mag     = {1'b0, w_sq_r} + {1'b0, w_sq_i};
    assign w_mag_esc = (r_k != '0) && (w_mag > ESC_BOUND);
    assign w_at_max  = (r_k == r_max_iter);

    assign w_out_free = !r_out_valid || o_rgb.ready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_pix.valid) n_state = ST_INIT;
            ST_INIT:   n_state = ST_MUL;
            ST_MUL:    n_state = ST_UPD;
            ST_UPD: begin
                if (w_mag_esc || (!w_at_max && w_oob)) begin
                    n_state = ST_DSTART;
                end else if (w_at_max) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DSTART: n_state = ST_DWAIT;
            ST_DWAIT:  if (w_div_rsp.done) n_state = ST_OUT;
            ST_OUT:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_x_start  <= -32'sd536870912;
            r_y_start  <= -32'sd268435456;
            r_x_step   <= 32'sd1258291;
            r_y_step   <= 32'sd1118481;
            r_max_iter <= 16'd256;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mandel_pkg::CFG_X_START:  r_x_start  <= i_cfg_data;
                    mandel_pkg::CFG_Y_START:  r_y_start  <= i_cfg_data;
                    mandel_pkg::CFG_X_STEP:   r_x_step   <= i_cfg_data;
                    mandel_pkg::CFG_Y_STEP:   r_y_step   <= i_cfg_data;
                    mandel_pkg::CFG_MAX_ITER: r_max_iter <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Per-pixel datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_col <= i_pix.col;
                r_row <= i_pix.row;
            end
            ST_INIT: begin
                r_cr <= w_cr_prod + C_W'(r_x_start);
                r_ci <= w_ci_prod + C_W'(r_y_start);
                r_zr <= '0;
                r_zi <= '0;
                r_k  <= '0;
            end
            ST_UPD: begin
                if (w_mag_esc) begin
                    r_esc <= r_k - 1'b1;
                    r_set <= 1'b0;
                end else if (w_at_max) begin
                    r_esc <= '0;
                    r_set <= 1'b1;
                end else begin
                    r_zr  <= w_nzr[mandel_pkg::Z_W-1:0];
                    r_zi  <= w_nzi[mandel_pkg::Z_W-1:0];
                    r_k   <= r_k + 1'b1;
                    r_esc <= r_k;
                    r_set <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Output register: loaded at the end of a pixel, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rgb.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_out_in_set <= r_set;
            r_out_esc    <= r_esc;
            r_out_red    <= r_set ? 8'd0 : w_div_rsp.quotient;
            r_out_green  <= r_set ? 7'd0 : w_div_rsp.quotient[7:1];
            r_out_blue   <= r_set ? 7'd0 : w_div_rsp.quotient[7:1];
        end
    end

    assign i_pix.ready       = (r_state == ST_IDLE);
    assign o_rgb.valid       = r_out_valid;
    assign o_rgb.red         = r_out_red;
    assign o_rgb.green       = r_out_green;
    assign o_rgb.blue        = r_out_blue;
    assign o_rgb.in_set      = r_out_in_set;
    assign o_rgb.escape_step = r_out_esc;

    // A point in the set is reported black with a zero escape step.
    `ASSERT_CLK(a_set_black, (r_out_valid && r_out_in_set) |-> (r_out_esc == '0 && r_out_red == '0), "in-set pixel is not black")
    // Green is always half the red scale, and blue equals green.
    `ASSERT_CLK(a_green_half, r_out_valid |-> (r_out_green == r_out_red[7:1] && r_out_blue == r_out_green), "green/blue do not track red")
    // The iteration count never runs past the limit.
    `ASSERT_CLK(a_k_bound, (r_state == ST_UPD) |-> (r_k <= r_max_iter), "iteration count exceeds max_iter")
    // The divider only finishes while the sequencer waits for it.
    `ASSERT_CLK(a_div_done, w_div_rsp.done |-> (r_state == ST_DWAIT && $past(r_state) == ST_DWAIT), "divider done outside its wait")

endmodule

FILE: sv/mandel_sq_unit.sv
// Complex squaring unit: registered zr*zr, zi*zi and zr*zi of the orbit point.
// Depends on mandel_pkg for the operand and product widths.
module mandel_sq_unit (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [mandel_pkg::Z_W-1:0]      i_zr,
    input  logic signed [mandel_pkg::Z_W-1:0]      i_zi,
    output logic signed [mandel_pkg::PROD_W-1:0]   o_sq_r,
    output logic signed [mandel_pkg::PROD_W-1:0]   o_sq_i,
    output logic signed [mandel_pkg::PROD_W-1:0]   o_cross
);

    logic signed [mandel_pkg::PROD_W-1:0] r_sq_r;
    logic signed [mandel_pkg::PROD_W-1:0] r_sq_i;
    logic signed [mandel_pkg::PROD_W-1:0] r_cross;

    // Three exact products, captured when the sequencer asks for them.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_r  <= i_zr * i_zr;
            r_sq_i  <= i_zi * i_zi;
            r_cross <= i_zr * i_zi;
        end
    end

    assign o_sq_r  = r_sq_r;
    assign o_sq_i  = r_sq_i;
    assign o_cross = r_cross;

endmodule

FILE: sv/mandel_div_unit.sv
// Restoring divider for the color scale: one quotient bit per cycle.
// Depends on mandel_pkg for the request/response types and widths.
module mandel_div_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mandel_pkg::t_div_req    i_req,
    output mandel_pkg::t_div_rsp    o_rsp
);

    localparam int CNT_W = $clog2(mandel_pkg::QUO_W);

    logic                               r_busy;
    logic                               r_done;
    logic [CNT_W-1:0]                   r_cnt;
    logic [mandel_pkg::DVS_W-1:0]       r_rem;
    logic [mandel_pkg::DVS_W-1:0]       r_dvs;
    logic [mandel_pkg::QUO_W-1:0]       r_quo;

    logic [mandel_pkg::DVS_W:0]         w_shifted;
    logic [mandel_pkg::DVS_W:0]         w_diff;
    logic                               w_ge;

    // The quotient is known to fit in QUO_W bits, so the upper dividend bits
    // start as the partial remainder and only the low bits are walked.
    assign w_shifted = {r_rem, r_quo[mandel_pkg::QUO_W-1]};
    assign w_diff    = w_shifted - {1'b0, r_dvs};
    assign w_ge      = (w_shifted >= {1'b0, r_dvs});

    // Control: busy while stepping, done pulses after the last step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(mandel_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the low register shifts dividend bits out and quotient bits in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[mandel_pkg::DVD_W-1:mandel_pkg::QUO_W];
            r_quo <= i_req.dividend[mandel_pkg::QUO_W-1:0];
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[mandel_pkg::DVS_W-1:0]
                          : w_shifted[mandel_pkg::DVS_W-1:0];
            r_quo <= {r_quo[mandel_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: tb/mandelbrot_escape_time_pixel_test.sv
// Self-checking testbench for the escape-time pixel block: drives pixel coordinates,
// predicts each color transaction and compares it field by field.
// Depends on mandel_pkg, mandel_pix_if, mandel_rgb_if and mandelbrot_escape_time_pixel.
module mandelbrot_escape_time_pixel_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     COL_W       = mandel_pkg::COL_W;
    localparam int     ROW_W       = mandel_pkg::ROW_W;
    localparam int     ITER_W      = mandel_pkg::ITER_W;
    localparam int     FRAC_BITS   = 28;
    localparam longint COMP_LIMIT  = longint'(1) << 30;
    localparam longint ESC_BOUND   = longint'(1) << 58;
    localparam int     CYCLE_LIMIT = 4_000_000;
    localparam int     RANDOM_PHASES    = 10;
    localparam int     ITEMS_PER_PHASE  = 105;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_pixel_coord;

    typedef struct packed {
        t_pixel_coord       at;
        logic [7:0]         red;
        logic [6:0]         green;
        logic [6:0]         blue;
        logic               in_set;
        logic [ITER_W-1:0]  escape_step;
    } t_pixel_color;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_BURSTY
    } t_sink_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    mandel_pix_if pix_bus ();
    mandel_rgb_if rgb_bus ();

    mandelbrot_escape_time_pixel i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_bus),
        .o_rgb      (rgb_bus)
    );

    // Shadow copy of the view registers, starting from the reset values.
    longint      view_x_start  = -536870912;
    longint      view_y_start  = -268435456;
    longint      view_x_step   = 1258291;
    longint      view_y_step   = 1118481;
    int unsigned view_max_iter = 256;

    t_pixel_coord pending_pixels[$];
    t_pixel_color expected_colors[$];

    int          color_errors = 0;
    int          cycle_count  = 0;
    bit          offer_live   = 1'b0;
    int          burst_left   = 1;
    int          gap_left     = 0;
    t_sink_mode  sink_mode    = SINK_ALWAYS;
    int          sink_left    = 0;
    int          stall_left   = 0;
    t_pixel_color got_color;
    t_pixel_color want_color;

    // Clock generation.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Escape-time iteration of one pixel under the current view.
    function automatic t_pixel_color predict_color(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
        longint       cr;
        longint       ci;
        longint       zr;
        longint       zi;
        longint       re;
        longint       im;
        int unsigned  k;
        int unsigned  esc;
        int unsigned  scaled;
        bit           escaped;
        t_pixel_color res;
        cr = view_x_start + longint'(col) * view_x_step;
        ci = view_y_start + longint'(row) * view_y_step;
        zr = 0;
        zi = 0;
        esc = 0;
        escaped = 1'b0;
        for (k = 0; k < view_max_iter; k++) begin
            re = zr * zr - zi * zi;
            im = zr * zi;
            zr = (re >>> FRAC_BITS) + cr;
            zi = (im >>> (FRAC_BITS - 1)) + ci;
            if (zr > COMP_LIMIT || zr < -COMP_LIMIT || zi > COMP_LIMIT ||
                zi < -COMP_LIMIT || zr * zr + zi * zi > ESC_BOUND) begin
                escaped = 1'b1;
                esc = k;
                break;
            end
        end
        res = '0;
        res.at.col = col;
        res.at.row = row;
        if (escaped) begin
            scaled = esc * 255;
            res.red = 8'(scaled / view_max_iter);
            res.green = 7'(scaled / (2 * view_max_iter));
            res.blue = res.green;
            res.in_set = 1'b0;
            res.escape_step = ITER_W'(esc);
        end else begin
            res.in_set = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want,
                                   input t_pixel_coord at);
        $display("%0t ns: %s mismatch at col %0d row %0d: got %0d, expected %0d",
                 $time, field, at.col, at.row, got, want);
        color_errors++;
    endtask

    // Sample both handshakes at the rising edge: predict on input, check on output.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_bus.valid && pix_bus.ready) begin
                void'(pending_pixels.pop_front());
                expected_colors.push_back(predict_color(pix_bus.col, pix_bus.row));
                offer_live = 1'b0;
            end
            if (rgb_bus.valid && rgb_bus.ready) begin
                got_color = '0;
                got_color.red = rgb_bus.red;
                got_color.green = rgb_bus.green;
                got_color.blue = rgb_bus.blue;
                got_color.in_set = rgb_bus.in_set;
                got_color.escape_step = rgb_bus.escape_step;
                if (expected_colors.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0, got_color.at);
                end else begin
                    want_color = expected_colors.pop_front();
                    if (got_color.red !== want_color.red)
                        report_mismatch("red", got_color.red, want_color.red, want_color.at);
                    if (got_color.green !== want_color.green)
                        report_mismatch("green", got_color.green, want_color.green,
                                        want_color.at);
                    if (got_color.blue !== want_color.blue)
                        report_mismatch("blue", got_color.blue, want_color.blue,
                                        want_color.at);
                    if (got_color.in_set !== want_color.in_set)
                        report_mismatch("in_set", got_color.in_set, want_color.in_set,
                                        want_color.at);
                    if (got_color.escape_step !== want_color.escape_step)
                        report_mismatch("escape_step", got_color.escape_step,
                                        want_color.escape_step, want_color.at);
                end
            end
        end
    end

    // Coordinate driver: bursts of transactions separated by random gaps.
    always @(negedge i_clk) begin
        if (!offer_live) begin
            if (gap_left > 0) begin
                pix_bus.valid <= 1'b0;
                gap_left--;
            end else if (pending_pixels.size() > 0) begin
                pix_bus.valid <= 1'b1;
                pix_bus.col <= pending_pixels[0].col;
                pix_bus.row <= pending_pixels[0].row;
                offer_live = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = $urandom_range(0, 12);
                end
            end else begin
                pix_bus.valid <= 1'b0;
            end
        end
    end

    // Color receiver: stretches of always-ready, coin-flip and bursty stalls.
    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            sink_left = $urandom_range(20, 300);
        end
        sink_left--;
        case (sink_mode)
            SINK_ALWAYS: begin
                rgb_bus.ready <= 1'b1;
            end
            SINK_COIN: begin
                rgb_bus.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (stall_left > 0) begin
                    rgb_bus.ready <= 1'b0;
                    stall_left--;
                end else if ($urandom_range(0, 7) == 0) begin
                    rgb_bus.ready <= 1'b0;
                    stall_left = $urandom_range(0, 5);
                end else begin
                    rgb_bus.ready <= 1'b1;
                end
            end
        endcase
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Write all five view registers while the block is idle.
    task automatic program_view(input logic [31:0] x_start, input logic [31:0] y_start,
                                input logic [31:0] x_step, input logic [31:0] y_step,
                                input logic [15:0] max_iter);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= mandel_pkg::CFG_X_START;
        i_cfg_data <= x_start;
        @(negedge i_clk);
        i_cfg_idx <= mandel_pkg::CFG_Y_START;
        i_cfg_data <= y_start;
        @(negedge i_clk);
        i_cfg_idx <= mandel_pkg::CFG_X_STEP;
        i_cfg_data <= x_step;
        @(negedge i_clk);
        i_cfg_idx <= mandel_pkg::CFG_Y_STEP;
        i_cfg_data <= y_step;
        @(negedge i_clk);
        i_cfg_idx <= mandel_pkg::CFG_MAX_ITER;
        i_cfg_data <= {16'd0, max_iter};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        view_x_start = longint'($signed(x_start));
        view_y_start = longint'($signed(y_start));
        view_x_step = longint'($signed(x_step));
        view_y_step = longint'($signed(y_step));
        view_max_iter = max_iter;
        @(posedge i_clk);
    endtask

    task automatic queue_pixel(input int col, input int row);
        t_pixel_coord pt;
        pt.col = COL_W'(col);
        pt.row = ROW_W'(row);
        pending_pixels.push_back(pt);
    endtask

    // Hold the sender back until every expected color has arrived.
    task automatic wait_until_drained();
        @(negedge i_clk);
        while (pending_pixels.size() != 0 || offer_live || expected_colors.size() != 0)
            @(negedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin
        int        xs;
        int        ys;
        int        xst;
        int        yst;
        int        mi;
        logic [31:0] raw_xs;
        logic [31:0] raw_ys;
        logic [31:0] raw_xst;
        logic [31:0] raw_yst;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = mandel_pkg::CFG_X_START;
        i_cfg_data = '0;
        pix_bus.valid = 1'b0;
        pix_bus.col = '0;
        pix_bus.row = '0;
        rgb_bus.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset view: first-step escape, in-set point, image corners and beyond.
        queue_pixel(0, 0);
        queue_pixel(373, 240);
        queue_pixel(639, 479);
        queue_pixel(1023, 511);
        queue_pixel(320, 100);
        wait_until_drained();

        // Zero view: c is zero everywhere, so every pixel stays in the set.
        program_view(32'h0, 32'h0, 32'h0, 32'h0, 16'd16);
        queue_pixel(1023, 511);
        queue_pixel(0, 0);
        wait_until_drained();

        // A single iteration.
        program_view(32'hE000_0000, 32'hF000_0000, 32'd1258291, 32'd1118481, 16'd1);
        queue_pixel(373, 240);
        queue_pixel(0, 0);
        queue_pixel(1023, 511);
        wait_until_drained();

        // Zero iteration limit: reported in set without any division.
        program_view(32'hE000_0000, 32'hF000_0000, 32'd1258291, 32'd1118481, 16'd0);
        queue_pixel(373, 240);
        queue_pixel(0, 0);
        wait_until_drained();

        // Largest iteration limit: one full in-set orbit and two fast escapes.
        program_view(32'hE000_0000, 32'hF000_0000, 32'd1258291, 32'd1118481, 16'hFFFF);
        queue_pixel(373, 240);
        queue_pixel(0, 0);
        queue_pixel(600, 100);
        wait_until_drained();

        // Extreme starts and steps: the point lies far outside and escapes at once.
        program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        queue_pixel(0, 0);
        queue_pixel(1023, 511);
        queue_pixel(1023, 0);
        queue_pixel(0, 511);
        queue_pixel(639, 479);
        wait_until_drained();
        program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 16'd2);
        queue_pixel(5, 5);
        wait_until_drained();

        // Random views: mostly windows over the set, some raw register values.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if ($urandom_range(0, 4) == 0) begin
                raw_xs = $urandom;
                raw_ys = $urandom;
                raw_xst = $urandom;
                raw_yst = $urandom;
                program_view(raw_xs, raw_ys, raw_xst, raw_yst,
                             16'($urandom_range(1, 128)));
            end else begin
                xs = -671088640 + int'($urandom_range(0, 268435456));
                ys = -402653184 + int'($urandom_range(0, 268435456));
                xst = int'($urandom_range(50000, 800000));
                yst = int'($urandom_range(50000, 1500000));
                if ($urandom_range(0, 3) == 0) begin
                    xs = xs + 805306368;
                    xst = -xst;
                end
                if ($urandom_range(0, 3) == 0) begin
                    ys = ys + 671088640;
                    yst = -yst;
                end
                mi = ($urandom_range(0, 7) == 0) ? 256 : int'($urandom_range(1, 96));
                program_view(32'(xs), 32'(ys), 32'(xst), 32'(yst), 16'(mi));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_pixel($urandom_range(0, 1023), $urandom_range(0, 511));
            wait_until_drained();
        end

        // Let any trailing activity settle, then give the verdict.
        repeat (40) @(posedge i_clk);
        if (color_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
